### rtl/core/hdfd_pkg.sv
package hdfd_pkg;

  localparam logic [1:0] CMD_TEMP    = 2'd0;
  localparam logic [1:0] CMD_HUM     = 2'd1;
  localparam logic [1:0] CMD_REG     = 2'd2;
  localparam logic [1:0] CMD_REG_ALT = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_CRC  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  // x^8+x^5+x^4+1, top bit implied
  localparam logic [7:0] CRC_POLY = 8'h31;

  // floor(raw14*512/2387) by reciprocal 7028 = floor(2^24/2387), shift 15
  localparam logic [12:0] TEMP_RECIP   = 13'd7028;
  localparam int          TEMP_SHIFT   = 15;
  localparam logic [11:0] TEMP_DIV     = 12'd2387;
  localparam logic [12:0] TEMP_OFFSET  = 13'd937;

  // raw*625 >> 15 with raw = raw14*4
  localparam logic [11:0] HUM_MUL      = 12'd2500;
  localparam int          HUM_SHIFT    = 15;
  localparam logic [10:0] HUM_OFFSET   = 11'd60;

  typedef struct packed {
    logic        is_reg;
    logic        is_temp;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  crc_b0;
    logic [13:0] raw14;
    logic [26:0] tq_prod;
    logic [25:0] hum_prod;
  } s1_t;

  typedef struct packed {
    logic        is_reg;
    logic        is_temp;
    logic [1:0]  status;
    logic [7:0]  reg_byte;
    logic [13:0] raw14;
    logic [11:0] q_est;
    logic [23:0] qm;
    logic [10:0] hum_val;
  } s2_t;

  typedef struct packed {
    logic               is_reg;
    logic               is_temp;
    logic [1:0]         status;
    logic [7:0]         reg_byte;
    logic signed [11:0] temp_val;
    logic [10:0]        hum_val;
  } s3_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/hdfd_if.sv
interface hdfd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] check_byte;

  modport source(output valid, command, first_byte, second_byte, check_byte, input ready);
  modport sink(input valid, command, first_byte, second_byte, check_byte, output ready);
endinterface

interface hdfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] value;
  logic [1:0]         status;
  logic               write_back;

  modport source(output valid, value, status, write_back, input ready);
  modport sink(input valid, value, status, write_back, output ready);
endinterface

### rtl/core/hdfd_stage_front.sv
module hdfd_stage_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [1:0]    command,
  input  logic [7:0]    first_byte,
  input  logic [7:0]    second_byte,
  input  logic [7:0]    check_byte,
  output logic          s1_valid,
  output hdfd_pkg::s1_t s1
);
  import hdfd_pkg::*;

  logic [13:0] raw14;

  // low two status bits dropped
  assign raw14 = {first_byte, second_byte[7:2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.is_reg   <= command[1];
      s1.is_temp  <= (command == CMD_TEMP);
      s1.b0       <= first_byte;
      s1.b1       <= second_byte;
      s1.b2       <= check_byte;
      s1.crc_b0   <= crc8_byte(8'd0, first_byte);
      s1.raw14    <= raw14;
      s1.tq_prod  <= {13'd0, raw14} * {14'd0, TEMP_RECIP};
      s1.hum_prod <= {12'd0, raw14} * {14'd0, HUM_MUL};
    end
  end

endmodule

### rtl/core/hdfd_stage_check.sv
module hdfd_stage_check (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          s1_valid,
  input  hdfd_pkg::s1_t s1,
  output logic          s2_valid,
  output hdfd_pkg::s2_t s2
);
  import hdfd_pkg::*;

  logic [7:0]  crc_frame;
  logic [1:0]  status;
  logic [11:0] q_est;
  logic [10:0] hum_raw;
  logic [10:0] hum_val;

  assign crc_frame = crc8_byte(s1.crc_b0, s1.b1);
  assign q_est     = s1.tq_prod[TEMP_SHIFT +: 12];
  assign hum_raw   = s1.hum_prod[HUM_SHIFT +: 11];
  assign hum_val   = (hum_raw < HUM_OFFSET) ? 11'd0 : hum_raw - HUM_OFFSET;

  always_comb begin
    if (s1.is_reg) begin
      // zero register wins over the crc test
      if (s1.b0 == 8'd0) begin
        status = STATUS_ZERO;
      end else if (s1.crc_b0 == s1.b1) begin
        status = STATUS_OK;
      end else begin
        status = STATUS_CRC;
      end
    end else begin
      status = (crc_frame == s1.b2) ? STATUS_OK : STATUS_CRC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.is_reg   <= s1.is_reg;
      s2.is_temp  <= s1.is_temp;
      s2.status   <= status;
      s2.reg_byte <= s1.b0;
      s2.raw14    <= s1.raw14;
      s2.q_est    <= q_est;
      s2.qm       <= {12'd0, q_est} * {12'd0, TEMP_DIV};
      s2.hum_val  <= hum_val;
    end
  end

endmodule

### rtl/core/hdfd_stage_temp.sv
module hdfd_stage_temp (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          s2_valid,
  input  hdfd_pkg::s2_t s2,
  output logic          s3_valid,
  output hdfd_pkg::s3_t s3
);
  import hdfd_pkg::*;

  logic [23:0]        num;
  logic [23:0]        rem;
  logic [11:0]        q;
  logic signed [12:0] t;
  logic signed [12:0] t_adj;

  assign num = {1'b0, s2.raw14, 9'd0};
  // estimate is exact or one short
  assign rem = num - s2.qm;
  assign q   = s2.q_est + {11'd0, (rem >= {12'd0, TEMP_DIV})};
  assign t   = $signed({1'b0, q}) - $signed(TEMP_OFFSET);
  // halve rounding toward zero
  assign t_adj = t + $signed({12'd0, t[12]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.is_reg   <= s2.is_reg;
      s3.is_temp  <= s2.is_temp;
      s3.status   <= s2.status;
      s3.reg_byte <= s2.reg_byte;
      s3.temp_val <= $signed(t_adj[12:1]);
      s3.hum_val  <= s2.hum_val;
    end
  end

endmodule

### rtl/core/humidity_temp_frame_decoder.sv
// Sensor reply frame decoder. Each request carries one temperature, humidity or
// user-register reply frame; the block checks its CRC-8 (poly 0x131, init 0) and
// returns one result: the scaled value in tenths of a degree or percent, or the
// register byte with write_back set, or value 0 with a CRC or zero-register
// status. Four register stages (register crc and scaling products, frame crc
// and quotient estimate, quotient correction and halving, output select) lie
// between acceptance and a valid result. A request can be taken every cycle;
// the whole pipeline holds while a result waits unread.
module humidity_temp_frame_decoder (
  input logic clk,
  input logic rst,
  hdfd_in_if.sink    frame,
  hdfd_out_if.source result
);
  import hdfd_pkg::*;

  logic  en;
  logic  s1_valid;
  logic  s2_valid;
  logic  s3_valid;
  s1_t   s1;
  s2_t   s2;
  s3_t   s3;
  logic  res_valid;
  logic signed [11:0] value_next;
  logic               wb_next;

  assign en          = !res_valid || result.ready;
  assign frame.ready = en;

  hdfd_stage_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (frame.valid),
    .command     (frame.command),
    .first_byte  (frame.first_byte),
    .second_byte (frame.second_byte),
    .check_byte  (frame.check_byte),
    .s1_valid    (s1_valid),
    .s1          (s1)
  );

  hdfd_stage_check u_check (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  hdfd_stage_temp u_temp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s3_valid (s3_valid),
    .s3       (s3)
  );

  always_comb begin
    value_next = 12'sd0;
    wb_next    = 1'b0;
    if (s3.status == STATUS_OK) begin
      if (s3.is_reg) begin
        value_next = $signed({4'd0, s3.reg_byte});
        wb_next    = 1'b1;
      end else if (s3.is_temp) begin
        value_next = s3.temp_val;
      end else begin
        value_next = $signed({1'b0, s3.hum_val});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.value      <= value_next;
      result.status     <= s3.status;
      result.write_back <= wb_next;
    end
  end

  assign result.valid = res_valid;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hdfd_pkg::*;

  localparam int NUM_DIRECTED   = 24;
  localparam int RANDOM_PER_PHASE = 275;
  localparam int STALL_LIMIT    = 5000;
  localparam int DRAIN_CYCLES   = 12;

  typedef enum logic [1:0] {
    FIX_NONE,
    FIX_GOOD,
    FIX_BAD
  } crc_fix_e;

  typedef struct packed {
    logic signed [11:0] value;
    logic [1:0]         status;
    logic               write_back;
  } frame_result_t;

  typedef struct packed {
    logic [1:0]    cmd;
    logic [7:0]    b0;
    logic [7:0]    b1;
    logic [7:0]    b2;
    crc_fix_e      fix;
    logic          typed;
    frame_result_t want;
  } frame_row_t;

  logic clk;
  logic rst;

  hdfd_in_if  frame();
  hdfd_out_if result();

  humidity_temp_frame_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame.sink),
    .result (result.source)
  );

  frame_result_t pending_results[$];
  int            error_count;
  int            frames_sent;
  int            results_checked;
  int            kind_count[4];
  int            status_count[4];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            quiet_cycles;

  // typed rows hold results that follow straight from the frame rules
  frame_row_t directed_rows[NUM_DIRECTED] = '{
    '{CMD_TEMP,    8'h00, 8'h00, 8'h00, FIX_NONE, 1'b1, '{-12'sd468, STATUS_OK,   1'b0}},
    '{CMD_HUM,     8'h00, 8'h00, 8'h00, FIX_NONE, 1'b1, '{12'sd0,    STATUS_OK,   1'b0}},
    '{CMD_TEMP,    8'h00, 8'h00, 8'hFF, FIX_NONE, 1'b1, '{12'sd0,    STATUS_CRC,  1'b0}},
    '{CMD_HUM,     8'h00, 8'h00, 8'h01, FIX_NONE, 1'b1, '{12'sd0,    STATUS_CRC,  1'b0}},
    '{CMD_TEMP,    8'hFF, 8'hFF, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_HUM,     8'hFF, 8'hFF, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_TEMP,    8'hFF, 8'hFF, 8'h00, FIX_BAD,  1'b1, '{12'sd0,    STATUS_CRC,  1'b0}},
    '{CMD_HUM,     8'hFF, 8'h00, 8'h00, FIX_BAD,  1'b1, '{12'sd0,    STATUS_CRC,  1'b0}},
    '{CMD_TEMP,    8'h00, 8'h03, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_HUM,     8'h0C, 8'h4C, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_HUM,     8'h0C, 8'h48, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_TEMP,    8'h44, 8'h30, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_TEMP,    8'h44, 8'h42, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_TEMP,    8'h80, 8'h00, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_REG,     8'h00, 8'h00, 8'h00, FIX_NONE, 1'b1, '{12'sd0,    STATUS_ZERO, 1'b0}},
    '{CMD_REG,     8'h00, 8'hFF, 8'hFF, FIX_NONE, 1'b1, '{12'sd0,    STATUS_ZERO, 1'b0}},
    '{CMD_REG,     8'hFF, 8'h00, 8'hFF, FIX_GOOD, 1'b1, '{12'sd255,  STATUS_OK,   1'b1}},
    '{CMD_REG,     8'h01, 8'h00, 8'h00, FIX_GOOD, 1'b1, '{12'sd1,    STATUS_OK,   1'b1}},
    '{CMD_REG,     8'hFF, 8'h00, 8'h00, FIX_BAD,  1'b1, '{12'sd0,    STATUS_CRC,  1'b0}},
    '{CMD_REG_ALT, 8'h80, 8'h00, 8'hAA, FIX_GOOD, 1'b1, '{12'sd128,  STATUS_OK,   1'b1}},
    '{CMD_REG_ALT, 8'h00, 8'h31, 8'h00, FIX_NONE, 1'b1, '{12'sd0,    STATUS_ZERO, 1'b0}},
    '{CMD_REG_ALT, 8'h7F, 8'h00, 8'h00, FIX_BAD,  1'b1, '{12'sd0,    STATUS_CRC,  1'b0}},
    '{CMD_HUM,     8'hAA, 8'h55, 8'h00, FIX_GOOD, 1'b0, '0},
    '{CMD_TEMP,    8'h55, 8'hAA, 8'h00, FIX_BAD,  1'b1, '{12'sd0,    STATUS_CRC,  1'b0}}
  };

  // bitwise crc-8, msb first, feedback taken from data and crc top bit
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] acc;
    logic       fb;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ data[i];
      acc = {acc[6:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic logic [7:0] frame_crc(input logic [1:0] cmd, input logic [7:0] b0,
                                           input logic [7:0] b1);
    if (cmd[1]) begin
      return crc8_update(8'h00, b0);
    end
    return crc8_update(crc8_update(8'h00, b0), b1);
  endfunction

  function automatic frame_result_t decode_frame(input logic [1:0] cmd, input logic [7:0] b0,
                                                 input logic [7:0] b1, input logic [7:0] b2);
    frame_result_t res;
    int            raw;
    int            scaled;
    res = '{12'sd0, STATUS_OK, 1'b0};
    if (cmd[1]) begin
      if (b0 == 8'h00) begin
        res.status = STATUS_ZERO;
      end else if (frame_crc(cmd, b0, b1) == b1) begin
        res.value      = $signed({4'b0000, b0});
        res.write_back = 1'b1;
      end else begin
        res.status = STATUS_CRC;
      end
    end else if (frame_crc(cmd, b0, b1) != b2) begin
      res.status = STATUS_CRC;
    end else begin
      raw = {16'd0, b0, b1[7:2], 2'b00};
      if (cmd == CMD_TEMP) begin
        scaled = ((raw * 512) / 9548) - 937;
        // integer division truncates toward zero, as the halving needs
        scaled = scaled / 2;
      end else begin
        scaled = ((raw * 625) >>> 15) - 60;
        if (scaled < 0) begin
          scaled = 0;
        end
      end
      res.value = scaled[11:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_result();
    frame_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result value=%0d status=%0d write_back=%0d with no request pending",
                                result.value, result.status, result.write_back));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    status_count[result.status]++;
    if (result.value !== want.value) begin
      report_mismatch($sformatf("value got %0d want %0d", result.value, want.value));
    end
    if (result.status !== want.status) begin
      report_mismatch($sformatf("status got %0d want %0d", result.status, want.status));
    end
    if (result.write_back !== want.write_back) begin
      report_mismatch($sformatf("write_back got %0d want %0d", result.write_back,
                                want.write_back));
    end
  endtask

  // called and returns at a falling edge
  task automatic send_frame(input frame_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      frame.valid       = 1'b0;
      frame.command     = 2'($urandom);
      frame.first_byte  = 8'($urandom);
      frame.second_byte = 8'($urandom);
      frame.check_byte  = 8'($urandom);
      @(negedge clk);
    end
    frame.valid       = 1'b1;
    frame.command     = row.cmd;
    frame.first_byte  = row.b0;
    frame.second_byte = row.b1;
    frame.check_byte  = row.b2;
    do @(posedge clk); while (!frame.ready);
    pending_results.push_back(row.typed ? row.want : decode_frame(row.cmd, row.b0, row.b1, row.b2));
    frames_sent++;
    kind_count[row.cmd]++;
    @(negedge clk);
  endtask

  function automatic frame_row_t apply_crc_fix(input frame_row_t row);
    frame_row_t fixed;
    logic [7:0] good;
    fixed = row;
    good  = frame_crc(row.cmd, row.b0, row.b1);
    if (row.fix != FIX_NONE) begin
      if (row.fix == FIX_BAD) begin
        good = good ^ 8'h01;
      end
      if (row.cmd[1]) begin
        fixed.b1 = good;
      end else begin
        fixed.b2 = good;
      end
    end
    return fixed;
  endfunction

  function automatic frame_row_t random_frame();
    frame_row_t row;
    row.cmd   = 2'($urandom_range(3));
    row.b0    = 8'($urandom);
    row.b1    = 8'($urandom);
    row.b2    = 8'($urandom);
    row.typed = 1'b0;
    row.want  = '0;
    if (row.cmd[1] && $urandom_range(9) == 0) begin
      row.b0 = 8'h00;
    end
    // mostly frames that pass the check, the rest carry a random check byte
    row.fix = ($urandom_range(99) < 80) ? FIX_GOOD : FIX_NONE;
    return apply_crc_fix(row);
  endfunction

  always #1 clk = ~clk;

  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      result.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      check_result();
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((frame.valid && frame.ready) || (result.valid && result.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles, %0d results outstanding", quiet_cycles,
                 pending_results.size());
        $display("humidity_temp_frame_decoder test failed");
        $finish;
      end
    end
  end

  initial begin
    int send_pct[4];
    int recv_pct[4];
    clk               = 1'b0;
    rst               = 1'b1;
    frame.valid       = 1'b0;
    frame.command     = CMD_TEMP;
    frame.first_byte  = 8'h00;
    frame.second_byte = 8'h00;
    frame.check_byte  = 8'h00;
    error_count       = 0;
    frames_sent       = 0;
    results_checked   = 0;
    kind_count        = '{default: 0};
    status_count      = '{default: 0};
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    send_pct = '{0, 85, 0, 35};
    recv_pct = '{0, 0, 85, 35};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_frame(apply_crc_fix(directed_rows[i]));
    end

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        send_frame(random_frame());
      end
    end
    frame.valid = 1'b0;
    recv_stall_pct = 0;

    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d frames: %0d temperature, %0d humidity, %0d register, %0d odd command",
             frames_sent, kind_count[CMD_TEMP], kind_count[CMD_HUM], kind_count[CMD_REG],
             kind_count[CMD_REG_ALT]);
    $display("checked %0d results: %0d ok, %0d crc mismatch, %0d zero register; %0d mismatches",
             results_checked, status_count[STATUS_OK], status_count[STATUS_CRC],
             status_count[STATUS_ZERO], error_count);
    if (error_count == 0) begin
      $display("humidity_temp_frame_decoder test passed");
    end else begin
      $display("humidity_temp_frame_decoder test failed");
    end
    $finish;
  end

endmodule
